>>> rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SRT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`else

`define SRT_ASSERT_IMP(label, clk, rst, ante, cons)

`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/srt_pkg.sv
package srt_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int TIME_WIDTH_DEF    = 16;
  localparam int SLOT_W            = 4;
  localparam int SLOT_LIMIT        = 2 ** SLOT_W;
  localparam int STAMP_W           = 16;
  localparam int CFG_W             = 5;
  localparam int METRIC_W          = 32;
  localparam int WIDE_W            = 34;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [STAMP_W-1:0] arrival_time;
    logic [STAMP_W-1:0] burst_time;
  } srt_item_t;

  typedef struct packed {
    logic                busy_res;
    logic [SLOT_W-1:0]   running_slot;
    logic                finished;
    logic [METRIC_W-1:0] waiting_time;
    logic [METRIC_W-1:0] turnaround_time;
    logic                all_done;
  } srt_result_t;

  typedef struct packed {
    logic capture;
    logic load_write;
    logic scan_step;
    logic update;
    logic out_load;
  } srt_cmd_t;

  typedef struct packed {
    logic is_load;
    logic cnt_zero;
    logic scan_last;
  } srt_stat_t;

endpackage

>>> rtl/srt_if.sv
interface srt_job_if;
  import srt_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [SLOT_W-1:0]  slot;
  logic [STAMP_W-1:0] arrival_time;
  logic [STAMP_W-1:0] burst_time;

  modport source (output valid, output kind, output slot, output arrival_time,
                  output burst_time, input ready);
  modport sink (input valid, input kind, input slot, input arrival_time,
                input burst_time, output ready);
endinterface

interface srt_report_if;
  import srt_pkg::*;

  logic                valid;
  logic                ready;
  logic                busy_res;
  logic [SLOT_W-1:0]   running_slot;
  logic                finished;
  logic [METRIC_W-1:0] waiting_time;
  logic [METRIC_W-1:0] turnaround_time;
  logic                all_done;

  modport source (output valid, output busy_res, output running_slot, output finished,
                  output waiting_time, output turnaround_time, output all_done,
                  input ready);
  modport sink (input valid, input busy_res, input running_slot, input finished,
                input waiting_time, input turnaround_time, input all_done,
                output ready);
endinterface

>>> rtl/srt_datapath.sv
`include "assert_macros.svh"

module srt_datapath #(
  parameter int MAX_PROCESSES = srt_pkg::MAX_PROCESSES_DEF,
  parameter int TIME_WIDTH    = srt_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [srt_pkg::CFG_W-1:0]  cfg_wr_data,
  input  srt_pkg::srt_item_t         job_item,
  input  srt_pkg::srt_cmd_t          cmd,
  output srt_pkg::srt_stat_t         stat,
  output srt_pkg::srt_result_t       result
);
  import srt_pkg::*;

  localparam int DEPTH  = (MAX_PROCESSES < SLOT_LIMIT) ? MAX_PROCESSES : SLOT_LIMIT;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (TIME_WIDTH > STAMP_W) ? TIME_WIDTH : STAMP_W;

  logic [CFG_W-1:0]      process_count;
  logic [CNT_W-1:0]      cnt;
  logic [STAMP_W-1:0]    arrival_mem [DEPTH];
  logic [STAMP_W-1:0]    burst_mem [DEPTH];
  logic [STAMP_W-1:0]    remaining [DEPTH];
  logic [DEPTH-1:0]      active;
  srt_item_t             item;
  logic [TIME_WIDTH-1:0] tick;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      best;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_slot;
  logic                  found;
  logic [STAMP_W-1:0]    best_rem;
  logic                  busy;
  logic                  fin;
  logic [WIDE_W-1:0]     dma;
  logic [STAMP_W-1:0]    burst_r;
  logic [STAMP_W-1:0]    rd_arr;
  logic [STAMP_W-1:0]    rd_bur;
  logic [STAMP_W-1:0]    rd_rem;
  logic                  elig;
  logic                  slot_ok;
  logic [WIDE_W-1:0]     done_ext;
  logic [WIDE_W-1:0]     wdiff;
  logic [METRIC_W-1:0]   turn_val;
  logic [METRIC_W-1:0]   wait_val;

  always_comb begin
    if (int'(process_count) > DEPTH) begin
      cnt = CNT_W'(DEPTH);
    end else begin
      cnt = CNT_W'(process_count);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      active[i] = (remaining[i] != '0) && (CNT_W'(i) < cnt);
    end
  end

  assign slot_ok = int'(item.slot) < MAX_PROCESSES;
  assign wr_slot = item.slot[IDX_W-1:0];
  assign rd_addr = cmd.scan_step ? idx : best;
  assign rd_arr  = arrival_mem[rd_addr];
  assign rd_bur  = burst_mem[rd_addr];
  assign rd_rem  = remaining[rd_addr];

  assign elig = (CMP_W'(rd_arr) <= CMP_W'(tick)) && (rd_rem != '0) &&
                (!found || (rd_rem < best_rem));

  assign done_ext = WIDE_W'(tick) + WIDE_W'(1);

  assign stat.is_load   = item.kind == KIND_LOAD;
  assign stat.cnt_zero  = cnt == '0;
  assign stat.scan_last = (CNT_W'(idx) + CNT_W'(1)) == cnt;

  // The difference carries a sign bit on top so that a negative span reads as zero.
  always_comb begin
    wdiff = dma - WIDE_W'(burst_r);
    if (dma[WIDE_W-1]) begin
      turn_val = '0;
    end else if (|dma[WIDE_W-2:METRIC_W]) begin
      turn_val = '1;
    end else begin
      turn_val = dma[METRIC_W-1:0];
    end
    if (dma[WIDE_W-1] || wdiff[WIDE_W-1]) begin
      wait_val = '0;
    end else if (|wdiff[WIDE_W-2:METRIC_W]) begin
      wait_val = '1;
    end else begin
      wait_val = wdiff[METRIC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= CFG_W'(1);
      tick          <= '0;
      idx           <= '0;
      found         <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        remaining[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        process_count <= cfg_wr_data;
      end
      if (cmd.capture) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (cmd.load_write && slot_ok) begin
        remaining[wr_slot] <= item.burst_time;
        tick               <= '0;
      end
      if (cmd.scan_step) begin
        idx <= idx + IDX_W'(1);
        if (elig) begin
          found <= 1'b1;
        end
      end
      if (cmd.update) begin
        if (found) begin
          remaining[best] <= best_rem - STAMP_W'(1);
        end
        if (tick != '1) begin
          tick <= tick + TIME_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= job_item;
      busy <= 1'b0;
      fin  <= 1'b0;
    end
    if (cmd.load_write && slot_ok) begin
      arrival_mem[wr_slot] <= item.arrival_time;
      burst_mem[wr_slot]   <= item.burst_time;
    end
    if (cmd.scan_step && elig) begin
      best     <= idx;
      best_rem <= rd_rem;
    end
    if (cmd.update && found) begin
      busy    <= 1'b1;
      fin     <= best_rem == STAMP_W'(1);
      dma     <= done_ext - WIDE_W'(rd_arr);
      burst_r <= rd_bur;
    end
    if (cmd.out_load) begin
      result.busy_res        <= busy;
      result.running_slot    <= busy ? SLOT_W'(best) : '0;
      result.finished        <= fin;
      result.waiting_time    <= fin ? wait_val : '0;
      result.turnaround_time <= fin ? turn_val : '0;
      result.all_done        <= ~|active;
    end
  end

  `SRT_ASSERT_IMP(a_scan_in_range, clk, rst, cmd.scan_step, CNT_W'(idx) < cnt)
  `SRT_ASSERT_IMP(a_found_live, clk, rst, found, best_rem != '0)
  `SRT_ASSERT_NEXT(a_load_clears_tick, clk, rst, cmd.load_write && slot_ok, tick == '0)

endmodule

>>> rtl/srt_ctrl.sv
`include "assert_macros.svh"

module srt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  output logic               report_valid,
  input  logic               report_ready,
  input  srt_pkg::srt_stat_t stat,
  output srt_pkg::srt_cmd_t  cmd
);
  import srt_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_UPDATE   = 3'd3;
  localparam logic [2:0] ST_RESULT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       tick_go;
  logic       load_go;

  assign job_ready = state == ST_IDLE;
  assign tick_go   = (state == ST_DISPATCH) && !stat.is_load && !stat.cnt_zero;
  assign load_go   = (state == ST_DISPATCH) && stat.is_load;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.is_load) begin
          cmd.load_write = 1'b1;
          state_next     = ST_RESULT;
        end else if (stat.cnt_zero) begin
          state_next = ST_UPDATE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!report_valid || report_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      report_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        report_valid <= 1'b1;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
    end
  end

  `SRT_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !report_valid || report_ready)
  `SRT_ASSERT_NEXT(a_tick_scans, clk, rst, tick_go, state == ST_SCAN)
  `SRT_ASSERT_NEXT(a_load_reports, clk, rst, load_go, state == ST_RESULT)

endmodule

>>> rtl/shortest_remaining_time_scheduler.sv
// Preemptive shortest-remaining-time scheduler. A load transaction stores one
// slot's arrival and burst time and restarts the time counter; a tick
// transaction runs the arrived slot with the least remaining time and reports
// its waiting and turnaround times when it completes. Every transaction yields
// one report. A load passes through the idle, dispatch and result states; a
// tick passes through idle, dispatch, scan, update and result. The scan covers
// the effective slot count, process_count limited to MAX_PROCESSES and to 16
// (skipped when it is zero), and visits one slot per cycle through the single
// read port of the slot tables. The next transaction is accepted as soon as
// the previous report has been loaded into the output register, even while
// that report waits.

module shortest_remaining_time_scheduler #(
  parameter int MAX_PROCESSES = srt_pkg::MAX_PROCESSES_DEF,
  parameter int TIME_WIDTH    = srt_pkg::TIME_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [srt_pkg::CFG_W-1:0] cfg_wr_data,
  srt_job_if.sink                   job,
  srt_report_if.source              report
);
  import srt_pkg::*;

  srt_item_t   job_item;
  srt_result_t result;
  srt_cmd_t    cmd;
  srt_stat_t   stat;

  assign job_item.kind         = job.kind;
  assign job_item.slot         = job.slot;
  assign job_item.arrival_time = job.arrival_time;
  assign job_item.burst_time   = job.burst_time;

  assign report.busy_res        = result.busy_res;
  assign report.running_slot    = result.running_slot;
  assign report.finished        = result.finished;
  assign report.waiting_time    = result.waiting_time;
  assign report.turnaround_time = result.turnaround_time;
  assign report.all_done        = result.all_done;

  srt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job.valid),
    .job_ready    (job.ready),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  srt_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job_item    (job_item),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

endmodule

>>> tb/sv/srt_report_check.sv
`timescale 1ns / 100ps

module srt_report_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [srt_pkg::CFG_W-1:0] cfg_wr_data,
  srt_job_if                        job,
  srt_report_if                     report,
  output int                        fail_count,
  output int                        outstanding
);
  import srt_pkg::*;

  logic [STAMP_W-1:0] arrival_tab   [SLOT_LIMIT];
  logic [STAMP_W-1:0] burst_tab     [SLOT_LIMIT];
  logic [STAMP_W-1:0] remaining_tab [SLOT_LIMIT];
  logic [STAMP_W-1:0] tick_now;
  logic [CFG_W-1:0]   proc_count;
  srt_result_t        pending_reports [$];

  function automatic srt_result_t schedule_step(input srt_item_t job_item);
    srt_result_t res;
    int          lim;
    int          pick;
    bit          found;
    int unsigned done;
    int unsigned arr;
    int unsigned bur;
    res = '0;
    lim = (proc_count > MAX_PROCESSES_DEF) ? MAX_PROCESSES_DEF : int'(proc_count);
    if (job_item.kind == KIND_LOAD) begin
      arrival_tab[job_item.slot]   = job_item.arrival_time;
      burst_tab[job_item.slot]     = job_item.burst_time;
      remaining_tab[job_item.slot] = job_item.burst_time;
      tick_now = '0;
    end else begin
      found = 1'b0;
      pick  = 0;
      for (int i = 0; i < lim; i++) begin
        if (arrival_tab[i] <= tick_now && remaining_tab[i] != '0 &&
            (!found || remaining_tab[i] < remaining_tab[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        res.busy_res     = 1'b1;
        res.running_slot = SLOT_W'(pick);
        remaining_tab[pick] = remaining_tab[pick] - STAMP_W'(1);
        if (remaining_tab[pick] == '0) begin
          done = METRIC_W'(tick_now) + METRIC_W'(1);
          arr  = METRIC_W'(arrival_tab[pick]);
          bur  = METRIC_W'(burst_tab[pick]);
          res.finished        = 1'b1;
          res.turnaround_time = (done >= arr) ? done - arr : '0;
          res.waiting_time    = (done >= arr + bur) ? done - arr - bur : '0;
        end
      end
      if (tick_now != '1) begin
        tick_now = tick_now + STAMP_W'(1);
      end
    end
    res.all_done = 1'b1;
    for (int i = 0; i < lim; i++) begin
      if (remaining_tab[i] != '0) begin
        res.all_done = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [METRIC_W-1:0] want,
                             input logic [METRIC_W-1:0] got);
    if (got !== want) begin
      if (fail_count < 50) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    srt_result_t want;
    srt_result_t got;
    srt_item_t   taken;
    if (rst) begin
      for (int i = 0; i < SLOT_LIMIT; i++) begin
        arrival_tab[i]   = '0;
        burst_tab[i]     = '0;
        remaining_tab[i] = '0;
      end
      tick_now   = '0;
      proc_count = CFG_W'(1);
      fail_count = 0;
      pending_reports.delete();
    end else begin
      if (cfg_wr_en) begin
        proc_count = cfg_wr_data;
      end
      if (report.valid && report.ready) begin
        got = {report.busy_res, report.running_slot, report.finished, report.waiting_time,
               report.turnaround_time, report.all_done};
        if (pending_reports.size() == 0) begin
          if (fail_count < 50) begin
            $display("%0t: unexpected report transaction, expected none, actual %h", $time, got);
          end
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("busy_res", METRIC_W'(want.busy_res), METRIC_W'(got.busy_res));
          check_field("running_slot", METRIC_W'(want.running_slot),
                      METRIC_W'(got.running_slot));
          check_field("finished", METRIC_W'(want.finished), METRIC_W'(got.finished));
          check_field("waiting_time", want.waiting_time, got.waiting_time);
          check_field("turnaround_time", want.turnaround_time, got.turnaround_time);
          check_field("all_done", METRIC_W'(want.all_done), METRIC_W'(got.all_done));
        end
      end
      if (job.valid && job.ready) begin
        taken = {job.kind, job.slot, job.arrival_time, job.burst_time};
        pending_reports.push_back(schedule_step(taken));
      end
    end
    outstanding = pending_reports.size();
  end

endmodule

>>> tb/sv/tb_shortest_remaining_time_scheduler.sv
`timescale 1ns / 100ps

module tb_shortest_remaining_time_scheduler;
  import srt_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  int fail_count;
  int outstanding;
  int send_idle    = 36;
  int recv_idle    = 66;
  int jobs_sent    = 0;
  int cycle_count  = 0;
  int count_now    = 1;
  bit hold_reports = 1'b0;
  int count_plan [12] = '{16, 0, 5, 31, 1, 16, 9, 20, 3, 16, 12, 2};

  srt_job_if    job_ch ();
  srt_report_if report_ch ();

  shortest_remaining_time_scheduler uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job         (job_ch),
    .report      (report_ch)
  );

  srt_report_check check_u (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job         (job_ch),
    .report      (report_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_shortest_remaining_time_scheduler failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    report_ch.ready <= !rst && !hold_reports && ($urandom_range(99) >= recv_idle);
  end

  // The report side stops for a long stretch so that the block stalls with a report pending.
  initial begin
    wait (jobs_sent >= 400);
    @(negedge clk);
    hold_reports <= 1'b1;
    repeat (500) @(negedge clk);
    hold_reports <= 1'b0;
  end

  task automatic send_job(input logic k, input logic [SLOT_W-1:0] s,
                          input logic [STAMP_W-1:0] a, input logic [STAMP_W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      job_ch.valid <= 1'b0;
      @(negedge clk);
    end
    job_ch.valid        <= 1'b1;
    job_ch.kind         <= k;
    job_ch.slot         <= s;
    job_ch.arrival_time <= a;
    job_ch.burst_time   <= b;
    do @(posedge clk); while (!job_ch.ready);
    jobs_sent++;
    @(negedge clk);
  endtask

  task automatic tick();
    send_job(KIND_TICK, SLOT_W'($urandom), STAMP_W'($urandom), STAMP_W'($urandom));
  endtask

  task automatic load_random(input int lim);
    logic [SLOT_W-1:0]  s;
    logic [STAMP_W-1:0] a;
    logic [STAMP_W-1:0] b;
    int                 r;
    s = (lim == 0 || $urandom_range(3) == 0) ? SLOT_W'($urandom_range(15))
                                             : SLOT_W'($urandom_range(lim - 1));
    a = ($urandom_range(9) == 0) ? STAMP_W'($urandom) : STAMP_W'($urandom_range(6));
    r = $urandom_range(9);
    b = (r == 0) ? '0 : (r == 1) ? STAMP_W'($urandom) : STAMP_W'($urandom_range(1, 6));
    send_job(KIND_LOAD, s, a, b);
  endtask

  task automatic set_count(input int c);
    job_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(c);
    count_now = c;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_batch(input int target);
    int sent;
    int n;
    int ticks;
    int lim;
    sent = 0;
    lim  = (count_now > MAX_PROCESSES_DEF) ? MAX_PROCESSES_DEF : count_now;
    while (sent < target) begin
      n = $urandom_range(1, 6);
      repeat (n) load_random(lim);
      ticks = $urandom_range(4, 30);
      repeat (ticks) begin
        if ($urandom_range(99) < 8) begin
          load_random(lim);
        end else begin
          tick();
        end
      end
      sent += n + ticks;
    end
  endtask

  initial begin
    job_ch.valid        = 1'b0;
    job_ch.kind         = KIND_LOAD;
    job_ch.slot         = '0;
    job_ch.arrival_time = '0;
    job_ch.burst_time   = '0;
    report_ch.ready     = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every slot is written before the first scan so that no stale entry is read.
    send_job(KIND_LOAD, 4'd0, 16'd0, 16'd3);
    send_job(KIND_LOAD, 4'd1, 16'd0, 16'd1);
    send_job(KIND_LOAD, 4'd2, 16'd1, 16'd1);
    send_job(KIND_LOAD, 4'd3, 16'd0, 16'd0);
    send_job(KIND_LOAD, 4'd4, 16'hFFFF, 16'hFFFF);
    send_job(KIND_LOAD, 4'd5, 16'd2, 16'd2);
    for (int i = 6; i < SLOT_LIMIT; i++) begin
      send_job(KIND_LOAD, SLOT_W'(i), (i % 2 == 1) ? 16'h5555 : 16'hAAAA, 16'd0);
    end
    tick();
    tick();
    set_count(16);
    repeat (6) tick();
    set_count(0);
    tick();
    set_count(31);
    tick();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 36 : (mode == 1) ? 66 : 0;
      recv_idle = (mode == 0) ? 66 : (mode == 1) ? 36 : 0;
      for (int k = 0; k < 4; k++) begin
        set_count(count_plan[mode * 4 + k]);
        run_batch(82);
      end
    end

    job_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_shortest_remaining_time_scheduler passed");
    end else begin
      $display("tb_shortest_remaining_time_scheduler failed");
    end
    $finish;
  end

endmodule
